>>> hw/rtl/edsc_pkg.sv
// Shared types, constants and helpers for the DER ECDSA signature checker.
// Used by the parser and the top level; no dependencies.

package edsc_pkg;

  localparam int unsigned MaxSigBytes     = 72;
  localparam int unsigned MaxPartBytesDef = 33;
  localparam int unsigned MinSigBytes     = 8;

  localparam logic [7:0] TagSequence = 8'h30;
  localparam logic [7:0] TagInteger  = 8'h02;
  localparam logic [7:0] SignMask    = 8'h80;

  // secp256k1 group order n and (n-1)/2, least significant byte at bit 0
  localparam logic [255:0] GroupOrder =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;
  localparam logic [255:0] HalfOrder =
    256'h7FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_5D576E73_57A4501D_DFE92F46_681B20A0;

  localparam logic [3:0] ReasonOk       = 4'd0;
  localparam logic [3:0] ReasonTotalLen = 4'd1;
  localparam logic [3:0] ReasonHeader   = 4'd2;
  localparam logic [3:0] ReasonRPart    = 4'd3;
  localparam logic [3:0] ReasonSPart    = 4'd4;
  localparam logic [3:0] ReasonTrailing = 4'd5;
  localparam logic [3:0] ReasonRRange   = 4'd6;
  localparam logic [3:0] ReasonSRange   = 4'd7;
  localparam logic [3:0] ReasonSHigh    = 4'd8;

  typedef struct packed {
    logic       take;
    logic [7:0] sig_byte;
    logic       last_byte;
  } edsc_in_t;

  typedef struct packed {
    logic       fire;
    logic [3:0] reason;
  } edsc_result_t;

  // lowest non-zero code wins
  function automatic logic [3:0] lower_code(logic [3:0] a, logic [3:0] b);
    logic [3:0] r;
    if (a == ReasonOk) begin
      r = b;
    end else if (b == ReasonOk) begin
      r = a;
    end else begin
      r = (a < b) ? a : b;
    end
    return r;
  endfunction

  // byte k of a 256-bit constant, counted from the least significant end
  function automatic logic [7:0] ref_byte(logic [255:0] value, logic [7:0] k);
    logic [7:0] r;
    if (k < 8'd32) begin
      r = value[{k[4:0], 3'b000} +: 8];
    end else begin
      r = 8'h00;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/edsc_channels_if.sv
// Valid/ready channel interfaces for signature bytes, verdicts and configuration.
// Depends on nothing beyond the language; used by the top level.

interface edsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] sig_byte;
  logic       last_byte;
  modport source (output valid, output sig_byte, output last_byte, input ready);
  modport sink   (input valid, input sig_byte, input last_byte, output ready);
endinterface

interface edsc_verdict_if;
  logic       valid;
  logic       ready;
  logic       canonical;
  logic [3:0] reason;
  modport source (output valid, output canonical, output reason, input ready);
  modport sink   (input valid, input canonical, input reason, output ready);
endinterface

interface edsc_cfg_if;
  logic valid;
  logic ready;
  logic strict_mode;
  modport source (output valid, output strict_mode, input ready);
  modport sink   (input valid, input strict_mode, output ready);
endinterface

>>> hw/rtl/edsc_parser.sv
// Byte-wise DER layout parser with range checks against the secp256k1 order.
// Depends on edsc_pkg; instantiated by ecdsa_der_signature_checker.

module edsc_parser
  import edsc_pkg::*;
#(
  parameter int unsigned MaxPartBytes = MaxPartBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  edsc_in_t     in_i,
  input  logic         strict_mode_i,
  output edsc_result_t result_o
);

  localparam int unsigned PartW    = $clog2(MaxPartBytes + 1);
  localparam logic [7:0]  MaxPartB = 8'(MaxPartBytes);
  localparam logic [7:0]  MaxSigB  = 8'(MaxSigBytes);
  localparam logic [7:0]  MinSigB  = 8'(MinSigBytes);

  typedef enum logic [3:0] {
    PhHdr, PhTotLen, PhRTag, PhRLen, PhRData, PhSTag, PhSLen, PhSData, PhDone, PhSink
  } phase_e;

  typedef enum logic [1:0] {CmpEq, CmpLt, CmpGt} cmp_e;

  function automatic cmp_e cmp_step(cmp_e s, logic [7:0] b, logic [7:0] r);
    cmp_e n;
    if (s != CmpEq) begin
      n = s;
    end else if (b < r) begin
      n = CmpLt;
    end else if (b > r) begin
      n = CmpGt;
    end else begin
      n = CmpEq;
    end
    return n;
  endfunction

  phase_e           phase_q, phase_d;
  logic [7:0]       count_q, count_d;
  logic [7:0]       total_q, total_d;
  logic [PartW-1:0] part_len_q, part_len_d;
  logic [PartW-1:0] part_idx_q, part_idx_d;
  logic             first_zero_q, first_zero_d;
  cmp_e             ord_cmp_q, ord_cmp_d;
  cmp_e             half_cmp_q, half_cmp_d;
  logic [3:0]       err_q, err_d;
  logic             too_long_q, too_long_d;

  logic [7:0]       b;
  logic [3:0]       part_code;
  logic             is_r;
  logic             tag_short;
  logic             len_over;
  logic             bad;
  logic [PartW-1:0] k;
  logic [PartW-1:0] idx_inc;
  cmp_e             ord_step;
  cmp_e             half_step;
  logic [3:0]       incomplete;
  logic [3:0]       verdict;

  assign b         = in_i.sig_byte;
  assign is_r      = (phase_q == PhRTag) || (phase_q == PhRLen) || (phase_q == PhRData);
  assign part_code = is_r ? ReasonRPart : ReasonSPart;
  assign tag_short = ({1'b0, total_q} + 9'd2) < ({1'b0, count_q} + 9'd3);
  assign len_over  = ({1'b0, b} + {1'b0, count_q}) > ({1'b0, total_q} + 9'd1);
  assign k         = part_len_q - PartW'(1) - part_idx_q;
  assign idx_inc   = part_idx_q + PartW'(1);
  assign ord_step  = cmp_step(ord_cmp_q, b, ref_byte(GroupOrder, 8'(k)));
  assign half_step = cmp_step(half_cmp_q, b, ref_byte(HalfOrder, 8'(k)));

  always_comb begin
    bad = 1'b0;
    if (part_idx_q == '0) begin
      bad = ((b & SignMask) != 8'h00) || ((b == 8'h00) && (part_len_q == PartW'(1)));
    end else if (part_idx_q == PartW'(1)) begin
      bad = first_zero_q && ((b & SignMask) == 8'h00);
    end
  end

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    total_d    = total_q;
    part_len_d = part_len_q;
    part_idx_d = part_idx_q;
    first_zero_d = first_zero_q;
    ord_cmp_d  = ord_cmp_q;
    half_cmp_d = half_cmp_q;
    err_d      = err_q;
    too_long_d = too_long_q;
    incomplete = ReasonOk;
    verdict    = ReasonOk;
    result_o   = '{fire: 1'b0, reason: ReasonOk};

    if (in_i.take) begin
      too_long_d = too_long_q || (count_q >= MaxSigB);
      count_d    = (count_q != 8'hFF) ? count_q + 8'd1 : count_q;

      case (phase_q)
        PhHdr: begin
          if (b != TagSequence) begin
            err_d   = lower_code(err_q, ReasonHeader);
            phase_d = PhSink;
          end else begin
            phase_d = PhTotLen;
          end
        end
        PhTotLen: begin
          total_d = b;
          phase_d = PhRTag;
        end
        PhRTag, PhSTag: begin
          if ((b != TagInteger) || tag_short) begin
            err_d   = lower_code(err_q, part_code);
            phase_d = PhSink;
          end else begin
            phase_d = (phase_q == PhRTag) ? PhRLen : PhSLen;
          end
        end
        PhRLen, PhSLen: begin
          if ((b == 8'h00) || (b > MaxPartB) || len_over) begin
            err_d   = lower_code(err_q, part_code);
            phase_d = PhSink;
          end else begin
            part_len_d   = PartW'(b);
            part_idx_d   = '0;
            first_zero_d = 1'b0;
            ord_cmp_d    = CmpEq;
            half_cmp_d   = CmpEq;
            phase_d      = (phase_q == PhRLen) ? PhRData : PhSData;
          end
        end
        PhRData, PhSData: begin
          if (part_idx_q == '0) begin
            first_zero_d = (b == 8'h00);
          end
          if (bad) begin
            err_d   = lower_code(err_q, part_code);
            phase_d = PhSink;
          end else begin
            ord_cmp_d  = ord_step;
            half_cmp_d = half_step;
            part_idx_d = idx_inc;
            if (idx_inc >= part_len_q) begin
              if (is_r) begin
                if (ord_step != CmpLt) begin
                  err_d = lower_code(err_q, ReasonRRange);
                end
                phase_d = PhSTag;
              end else begin
                if (ord_step != CmpLt) begin
                  err_d = lower_code(err_q, ReasonSRange);
                end else if (strict_mode_i && (half_step == CmpGt)) begin
                  err_d = lower_code(err_q, ReasonSHigh);
                end
                phase_d = PhDone;
              end
            end
          end
        end
        PhDone: begin
          err_d   = lower_code(err_q, ReasonTrailing);
          phase_d = PhSink;
        end
        default: begin
          phase_d = PhSink;
        end
      endcase

      if (in_i.last_byte) begin
        case (phase_d)
          PhHdr, PhTotLen:           incomplete = ReasonHeader;
          PhRTag, PhRLen, PhRData:   incomplete = ReasonRPart;
          PhSTag, PhSLen, PhSData:   incomplete = ReasonSPart;
          default:                   incomplete = ReasonOk;
        endcase
        if (too_long_d || (count_d < MinSigB) || (count_d > MaxSigB)) begin
          verdict = ReasonTotalLen;
        end else begin
          verdict = lower_code(err_d, incomplete);
          if (({1'b0, total_d} + 9'd2) != {1'b0, count_d}) begin
            verdict = lower_code(verdict, ReasonHeader);
          end
        end
        result_o = '{fire: 1'b1, reason: verdict};

        phase_d      = PhHdr;
        count_d      = '0;
        total_d      = '0;
        part_len_d   = '0;
        part_idx_d   = '0;
        first_zero_d = 1'b0;
        ord_cmp_d    = CmpEq;
        half_cmp_d   = CmpEq;
        err_d        = ReasonOk;
        too_long_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHdr;
      count_q      <= '0;
      total_q      <= '0;
      part_len_q   <= '0;
      part_idx_q   <= '0;
      first_zero_q <= 1'b0;
      ord_cmp_q    <= CmpEq;
      half_cmp_q   <= CmpEq;
      err_q        <= ReasonOk;
      too_long_q   <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      count_q      <= count_d;
      total_q      <= total_d;
      part_len_q   <= part_len_d;
      part_idx_q   <= part_idx_d;
      first_zero_q <= first_zero_d;
      ord_cmp_q    <= ord_cmp_d;
      half_cmp_q   <= half_cmp_d;
      err_q        <= err_d;
      too_long_q   <= too_long_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.take && in_i.last_byte |=>
      (phase_q == PhHdr) && (count_q == 8'd0) && (err_q == ReasonOk) && !too_long_q)
    else $error("parser state not cleared after final item");

  a_index_in_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhRData) || (phase_q == PhSData) |-> part_idx_q < part_len_q)
    else $error("part index beyond part length");

  a_sink_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSink |-> err_q != ReasonOk)
    else $error("parser sunk without a latched error");

endmodule

>>> hw/rtl/ecdsa_der_signature_checker.sv
// Top level of the DER ECDSA signature checker: handshakes, mode register, verdict register.
// Depends on edsc_pkg, the edsc channel interfaces and edsc_parser.
//
//  channel    | dir | payload                 | handshake
//  -----------+-----+-------------------------+-------------
//  sig_i      | in  | sig_byte[7:0] last_byte | valid/ready
//  verdict_o  | out | canonical reason[3:0]   | valid/ready
//  cfg_i      | in  | strict_mode             | valid/ready
//
// One byte is taken per cycle while sig_i.ready is high; the parser updates its state on the accepting edge.
// The verdict is registered in the cycle after the final byte is accepted.
// sig_i.ready falls only while a verdict is held and verdict_o.ready is low.
// rst_ni clears the parser, the verdict valid flag and strict_mode; the verdict payload is not reset.
// cfg_i is always ready; strict_mode is sampled on the final byte of S.

module ecdsa_der_signature_checker
  import edsc_pkg::*;
#(
  parameter int unsigned MaxPartBytes = MaxPartBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  edsc_byte_if.sink      sig_i,
  edsc_verdict_if.source verdict_o,
  edsc_cfg_if.sink       cfg_i
);

  logic         strict_q, strict_d;
  logic         out_valid_q, out_valid_d;
  logic         canonical_q;
  logic [3:0]   reason_q;
  edsc_in_t     parse_in;
  edsc_result_t parse_res;

  assign sig_i.ready = !out_valid_q || verdict_o.ready;
  assign cfg_i.ready = 1'b1;

  assign parse_in = '{take:      sig_i.valid && sig_i.ready,
                      sig_byte:  sig_i.sig_byte,
                      last_byte: sig_i.last_byte};

  edsc_parser #(
    .MaxPartBytes(MaxPartBytes)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (parse_in),
    .strict_mode_i(strict_q),
    .result_o     (parse_res)
  );

  always_comb begin
    strict_d    = (cfg_i.valid && cfg_i.ready) ? cfg_i.strict_mode : strict_q;
    out_valid_d = parse_res.fire ? 1'b1 : (verdict_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      strict_q    <= strict_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (parse_res.fire) begin
      canonical_q <= (parse_res.reason == ReasonOk);
      reason_q    <= parse_res.reason;
    end
  end

  assign verdict_o.valid     = out_valid_q;
  assign verdict_o.canonical = canonical_q;
  assign verdict_o.reason    = reason_q;

  a_canonical_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_o.valid |-> (verdict_o.canonical == (verdict_o.reason == ReasonOk)))
    else $error("canonical flag disagrees with reason");

  a_reason_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_o.valid |-> verdict_o.reason <= ReasonSHigh)
    else $error("reason code out of range");

  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sig_i.valid && sig_i.ready && sig_i.last_byte |=> verdict_o.valid)
    else $error("final item produced no verdict");

  a_no_spurious_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !verdict_o.valid && !(sig_i.valid && sig_i.ready && sig_i.last_byte) |=> !verdict_o.valid)
    else $error("verdict without a final item");

endmodule
